/* src/binary_to_decimal_ascii_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the binary-to-decimal ASCII unit
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define B2D_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b2d check failed");

// next-cycle implication, checked out of reset
`define B2D_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b2d check failed");

`else

`define B2D_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define B2D_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* src/b2d_pkg.sv */
// ----------------------------------------------------------------------------
// b2d_pkg
// Shared constants, command/status types and helpers for the converter.
// ----------------------------------------------------------------------------
package b2d_pkg;

  localparam int IN_WIDTH    = 64;  // port width of the value field
  localparam int VALUE_WIDTH = 64;  // converted bits, 8..64
  localparam int NUM_DIGITS  = 20;  // enough for any 64-bit value
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 6;
  localparam int BCD_W       = NUM_DIGITS * DIGIT_W;
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);

  // '0' truncated to the 6-bit character field
  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  typedef struct packed {
    logic load;   // capture a new value, clear the BCD accumulator
    logic shift;  // one double-dabble step
    logic find;   // locate the leading nonzero digit
    logic emit;   // load the next digit into the output register
  } b2d_cmd_t;

  typedef struct packed {
    logic bits_done;  // current shift consumes the last input bit
    logic idx_zero;   // digit pointer is on the least significant digit
    logic out_free;   // output register can take a digit this cycle
  } b2d_sts_t;

  // add-3 correction ahead of the shift
  function automatic logic [DIGIT_W-1:0] dd_adjust(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = (d >= DIGIT_W'(5)) ? d + DIGIT_W'(3) : d;
    return r;
  endfunction

endpackage

/* src/b2d_datapath.sv */
// ----------------------------------------------------------------------------
// b2d_datapath
// Double-dabble shift register, digit pointer and output register.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_unit_defines.svh"

module b2d_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [b2d_pkg::IN_WIDTH-1:0]  in_value,
  input  b2d_pkg::b2d_cmd_t             cmd,
  output b2d_pkg::b2d_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [b2d_pkg::CHAR_W-1:0]    out_digit_char,
  output logic                          out_last
);
  import b2d_pkg::*;

  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [DIGIT_IDX_W-1:0] idx_r, idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_digit_r, out_digit_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [BCD_W-1:0]       bcd_adj;
  logic [DIGIT_IDX_W-1:0] lead_idx;
  logic [DIGIT_W-1:0]     cur_digit;
  logic                   out_free;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i*DIGIT_W +: DIGIT_W] = dd_adjust(bcd_r[i*DIGIT_W +: DIGIT_W]);
    end
  end

  // highest nonzero digit wins; all-zero leaves the pointer on digit 0
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*DIGIT_W +: DIGIT_W] != '0) begin
        lead_idx = DIGIT_IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd_r[idx_r*DIGIT_W +: DIGIT_W];
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    val_nxt       = val_r;
    bit_cnt_nxt   = bit_cnt_r;
    bcd_nxt       = bcd_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_digit_nxt = out_digit_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.load) begin
      val_nxt     = in_value[VALUE_WIDTH-1:0];
      bit_cnt_nxt = BIT_CNT_W'(VALUE_WIDTH - 1);
      bcd_nxt     = '0;
    end
    if (cmd.shift) begin
      bcd_nxt     = {bcd_adj[BCD_W-2:0], val_r[VALUE_WIDTH-1]};
      val_nxt     = {val_r[VALUE_WIDTH-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
    end
    if (cmd.find) begin
      idx_nxt = lead_idx;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_digit_nxt = ASCII_ZERO | CHAR_W'(cur_digit);
      out_last_nxt  = (idx_r == '0);
      idx_nxt       = idx_r - DIGIT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    bcd_r       <= bcd_nxt;
    idx_r       <= idx_nxt;
    out_digit_r <= out_digit_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign sts.bits_done = (bit_cnt_r == '0);
  assign sts.idx_zero  = (idx_r == '0);
  assign sts.out_free  = out_free;

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_digit_r;
  assign out_last       = out_last_r;

  `B2D_ASSERT_IMP(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd))
  `B2D_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, !out_valid_r || out_ready)
  `B2D_ASSERT_IMP(a_digit_range, clk, rst_n, out_valid_r,
                  out_digit_r[DIGIT_W-1:0] <= DIGIT_W'(9))

endmodule

/* src/b2d_ctrl.sv */
// ----------------------------------------------------------------------------
// b2d_ctrl
// Sequencer: accept, convert bit by bit, find leading digit, emit digits.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_unit_defines.svh"

module b2d_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  b2d_pkg::b2d_sts_t sts,
  output b2d_pkg::b2d_cmd_t cmd
);
  import b2d_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        // ready stays low in reset; it is registered from the next state
        if (in_valid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (sts.bits_done) begin
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.idx_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_ready = in_ready_r;

  `B2D_ASSERT_IMP(a_load_ready, clk, rst_n, cmd.load, in_ready_r)
  `B2D_ASSERT_NXT(a_find_emit, clk, rst_n, state_r == ST_FIND, state_r == ST_EMIT)
  `B2D_ASSERT_NXT(a_last_idle, clk, rst_n, cmd.emit && sts.idx_zero, in_ready_r)

endmodule

/* src/binary_to_decimal_ascii_unit.sv */
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// Unsigned binary to decimal ASCII digit stream, most significant first.
// ----------------------------------------------------------------------------
// One value is taken at a time. After the transfer the value is converted by
// shift-and-add-3, one input bit per cycle, a find step locates the leading
// nonzero digit, then one digit per cycle goes to the output register while
// out_ready allows. Leading zeros are dropped; zero gives a single '0'.
// out_last flags the final digit; a value yields 1 to 20 digits. The last
// digit may still wait at the output while the next value is accepted and
// converted.

module binary_to_decimal_ascii_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [b2d_pkg::IN_WIDTH-1:0]  in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [b2d_pkg::CHAR_W-1:0]    out_digit_char,
  output logic                          out_last
);
  import b2d_pkg::*;

  b2d_cmd_t cmd;
  b2d_sts_t sts;

  b2d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  b2d_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for binary_to_decimal_ascii_unit. Each value transfer
// is converted to decimal digits here and queued; every digit transfer on
// the output side is checked against the oldest queued digit. Runs corner
// values, then random values under three idling mixes, with one long output
// hold-off that backs the unit up against its input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b2d_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 50000;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_exp_t;

  class decimal_text_checker;
    digit_exp_t expected_digits[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    // expand one value into its digit stream, most significant first
    function void note_value(logic [IN_WIDTH-1:0] raw);
      logic [63:0] mask;
      logic [63:0] v;
      logic [3:0]  decs[$];
      digit_exp_t  e;
      mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
      v = 64'(raw) & mask;
      do begin
        decs.push_front(4'(v % 64'd10));
        v = v / 64'd10;
      end while (v != 64'd0 && decs.size() < NUM_DIGITS);
      foreach (decs[k]) begin
        e.ch   = CHAR_W'(decs[k] + 8'd48);
        e.last = (k == decs.size() - 1);
        expected_digits.push_back(e);
      end
    endfunction

    function void check_digit(logic [CHAR_W-1:0] ch, logic last);
      digit_exp_t e;
      if (expected_digits.size() == 0) begin
        $display("%0t: unexpected digit: expected none, got char %0d last %0b",
                 $time, ch, last);
        mismatches++;
        return;
      end
      e = expected_digits.pop_front();
      if (ch !== e.ch) begin
        $display("%0t: digit_char: expected %0d, got %0d", $time, e.ch, ch);
        mismatches++;
      end
      if (last !== e.last) begin
        $display("%0t: last: expected %0b, got %0b", $time, e.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [IN_WIDTH-1:0] in_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CHAR_W-1:0]   out_digit_char;
  logic                out_last;

  int src_idle_pct = 15;
  int sink_idle_pct = 58;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  decimal_text_checker text_chk = new();

  binary_to_decimal_ascii_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin : sink
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      text_chk.check_digit(out_digit_char, out_last);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_value(input logic [IN_WIDTH-1:0] v);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      in_value <= {$urandom, $urandom};
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    text_chk.note_value(v);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    logic [63:0] v;
    logic [63:0] mag;
    int          nbits;
    repeat (count) begin
      case ($urandom_range(0, 9))
        6: v = {$urandom, $urandom};
        7: v = 64'($urandom_range(0, 20));
        8: begin
          // just around a power of ten, where the digit count changes
          mag = 64'd1;
          repeat ($urandom_range(0, 19)) mag = mag * 64'd10;
          v = mag + 64'($urandom_range(0, 2)) - 64'd1;
        end
        9: v = '1 - 64'($urandom_range(0, 1000));
        default: begin
          nbits = $urandom_range(1, 64);
          v = {$urandom, $urandom};
          if (nbits < 64) v = v & ((64'd1 << nbits) - 64'd1);
        end
      endcase
      send_value(v);
    end
  endtask

  initial begin : drive
    logic [63:0] corner_values[19];
    int          guard;
    corner_values = '{
      64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd255, 64'd256, 64'd65535,
      64'd4294967295, 64'd4294967296, 64'h8000000000000000,
      64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555,
      64'd1000000000000000000, 64'd9999999999999999999,
      64'd10000000000000000000, 64'd12345678901234567890,
      64'd18446744073709551615
    };

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (corner_values[k]) send_value(corner_values[k]);

    src_idle_pct = 15;
    sink_idle_pct = 58;
    send_random(140);

    src_idle_pct = 58;
    sink_idle_pct = 15;
    send_random(140);

    // long output stall while values keep coming
    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_req = 1'b1;
    send_random(130);

    in_valid <= 1'b0;
    guard = 0;
    while (text_chk.expected_digits.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    foreach (text_chk.expected_digits[k]) begin
      $display("%0t: missing digit: expected char %0d last %0b, got none", $time,
               text_chk.expected_digits[k].ch, text_chk.expected_digits[k].last);
      text_chk.mismatches++;
    end

    if (text_chk.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
